[sv/rclm_pkg.sv]
// ----------------------------------------------------------------------------
// rclm_pkg
// Shared types, codes and constants of the RTS/CTS link MAC engine.
// ----------------------------------------------------------------------------
package rclm_pkg;

    // packet queue geometry
    localparam int QUEUE_DEPTH = 8;
    localparam int QA_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QC_W        = $clog2(QUEUE_DEPTH + 1);

    // result queue geometry
    localparam int OQ_DEPTH = 4;
    localparam int OA_W     = $clog2(OQ_DEPTH);
    localparam int OC_W     = $clog2(OQ_DEPTH + 1);

    typedef logic [QA_W-1:0] t_qptr;
    typedef logic [QC_W-1:0] t_qcnt;
    typedef logic [OA_W-1:0] t_optr;
    typedef logic [OC_W-1:0] t_ocnt;

    // configuration register indexes
    localparam logic [2:0] CFG_OWN_ADDR   = 3'd0;
    localparam logic [2:0] CFG_BCAST_ADDR = 3'd1;
    localparam logic [2:0] CFG_MAX_ATT    = 3'd2;
    localparam logic [2:0] CFG_RSI_THR    = 3'd3;
    localparam logic [2:0] CFG_PWR_OFF    = 3'd4;
    localparam logic [2:0] CFG_MAX_PWR    = 3'd5;
    localparam logic [2:0] CFG_GATEWAY    = 3'd6;

    typedef enum logic [2:0] {
        OP_TICK    = 3'd0,
        OP_RTS_RX  = 3'd1,
        OP_CTS_RX  = 3'd2,
        OP_ACK_RX  = 3'd3,
        OP_ENQUEUE = 3'd4,
        OP_OTHER   = 3'd5
    } t_opcode;

    typedef enum logic [2:0] {
        LS_UNSYNC   = 3'd0,
        LS_IDLE     = 3'd1,
        LS_EXP_RTS  = 3'd2,
        LS_EXP_CTS  = 3'd3,
        LS_EXP_DATA = 3'd4,
        LS_EXP_ACK  = 3'd5
    } t_link_state;

    typedef enum logic [3:0] {
        ACT_RTS       = 4'd0,
        ACT_RTS_RSI   = 4'd1,
        ACT_BCAST     = 4'd2,
        ACT_DATA      = 4'd3,
        ACT_CTS       = 4'd4,
        ACT_DELIVERED = 4'd5,
        ACT_DROPPED   = 4'd6,
        ACT_ACCEPTED  = 4'd7,
        ACT_REJECTED  = 4'd8
    } t_action;

    // one packet queue entry
    typedef struct packed {
        logic [7:0] hop;
        logic [7:0] handle;
    } t_entry;

    // one result word as it leaves the block
    typedef struct packed {
        t_action     action;
        logic [7:0]  power;
        logic [7:0]  peer;
        logic [7:0]  handle;
        t_link_state ls;
        logic        last;
    } t_out_word;

    // queue pointer advance with wrap at the queue depth
    function automatic t_qptr qptr_inc(input t_qptr p);
        t_qptr r;
        if (p == QA_W'(QUEUE_DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + QA_W'(1);
        end
        return r;
    endfunction

endpackage

[sv/rts_cts_link_mac_engine.sv]
// ----------------------------------------------------------------------------
// rts_cts_link_mac_engine
// Slotted RTS/CTS/ACK link MAC with a queue of outgoing packet handles.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one event word: slot tick,
//   received RTS/CTS/ACK, enqueue request or other frame. Output channel
//   (o_out_valid / i_out_ready) carries zero, one or two result words per
//   event; o_last marks the final word of an event.
//   Every event is decided in the cycle it is accepted; its words are stored
//   in the result queue registers. One event per cycle is accepted as long as
//   the four-word result queue has room for two more words, so the sustained
//   rate is one event per cycle whenever results are drained at that rate.
//   The head and second queue entries are kept prefetched from the packet
//   RAM (registered read ports) at the pointer the current event leaves, with
//   write forwarding, so back-to-back events never wait on the RAM.
//   Reset returns the link to unsynchronized with an empty queue and the
//   register defaults; the RAM itself is not cleared. When the receiver
//   stalls, words collect in the result queue and o_in_ready drops once fewer
//   than two free slots remain. Registers are written through the APB port,
//   by the user only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module rts_cts_link_mac_engine (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // apb configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [4:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    // event input
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [2:0]        i_opcode,
    input  logic [7:0]        i_frame_source,
    input  logic [7:0]        i_frame_destination,
    input  logic              i_send_opportunity,
    input  logic [7:0]        i_peer_time_remaining,
    input  logic [6:0]        i_peer_link_loss,
    input  logic [7:0]        i_packet_handle,
    input  logic [7:0]        i_next_hop,
    // result output
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [3:0]        o_action,
    output logic signed [7:0] o_tx_power,
    output logic [7:0]        o_peer_address,
    output logic [7:0]        o_result_handle,
    output logic [2:0]        o_link_state_out,
    output logic              o_last
);
    import rclm_pkg::*;

    // configuration registers
    logic [7:0]  r_own_addr;
    logic [7:0]  r_bcast_addr;
    logic [3:0]  r_max_att;
    logic [7:0]  r_rsi_thr;
    logic [7:0]  r_pwr_off;
    logic [7:0]  r_max_pwr;
    logic        r_gateway;

    // link state
    t_link_state r_ls;
    logic [3:0]  r_att;
    logic [7:0]  r_radio;
    t_qptr       r_rd_ptr;
    t_qptr       r_wr_ptr;
    t_qcnt       r_cnt;

    t_link_state n_ls;
    logic [3:0]  n_att;
    logic [7:0]  n_radio;
    t_qptr       n_rd_ptr;
    t_qptr       n_wr_ptr;
    t_qcnt       n_cnt;

    // queue ram interface
    t_entry      w_head;
    t_entry      w_next;
    logic        w_we;
    t_entry      w_wdata;

    // result words
    t_out_word   w_word0;
    t_out_word   w_word1;
    logic [1:0]  w_push_n;
    logic        w_room2;
    t_out_word   w_oword;

    logic        w_accept;
    logic        w_cfg_wr;
    logic [2:0]  w_cfg_idx;
    t_opcode     w_op;

    // power and tick helpers
    logic signed [8:0] w_sum;
    logic [7:0]        w_sat_pwr;
    logic [7:0]        w_uni_pwr;
    t_link_state       w_ls0;
    logic [3:0]        w_att_inc;
    logic              w_reach;

    assign w_accept  = i_in_valid && o_in_ready;
    assign o_in_ready = w_room2;
    assign w_op      = t_opcode'(i_opcode);

    // apb register file
    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite;
    assign w_cfg_idx = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_addr   <= 8'd0;
            r_bcast_addr <= 8'd255;
            r_max_att    <= 4'd3;
            r_rsi_thr    <= 8'd16;
            r_pwr_off    <= 8'hA6;
            r_max_pwr    <= 8'd3;
            r_gateway    <= 1'b0;
        end else if (w_cfg_wr) begin
            case (w_cfg_idx)
                CFG_OWN_ADDR:   r_own_addr   <= pwdata[7:0];
                CFG_BCAST_ADDR: r_bcast_addr <= pwdata[7:0];
                CFG_MAX_ATT:    r_max_att    <= pwdata[3:0];
                CFG_RSI_THR:    r_rsi_thr    <= pwdata[7:0];
                CFG_PWR_OFF:    r_pwr_off    <= pwdata[7:0];
                CFG_MAX_PWR:    r_max_pwr    <= pwdata[7:0];
                CFG_GATEWAY:    r_gateway    <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_cfg_idx)
            CFG_OWN_ADDR:   prdata = {24'd0, r_own_addr};
            CFG_BCAST_ADDR: prdata = {24'd0, r_bcast_addr};
            CFG_MAX_ATT:    prdata = {28'd0, r_max_att};
            CFG_RSI_THR:    prdata = {24'd0, r_rsi_thr};
            CFG_PWR_OFF:    prdata = {24'd0, r_pwr_off};
            CFG_MAX_PWR:    prdata = {24'd0, r_max_pwr};
            CFG_GATEWAY:    prdata = {31'd0, r_gateway};
            default:        prdata = 32'd0;
        endcase
    end

    // unicast power: saturated offset plus link loss, or max at zero time left
    always_comb begin
        w_sum = $signed({r_pwr_off[7], r_pwr_off}) + $signed({2'b00, i_peer_link_loss});
        if (w_sum > 9'sd127) begin
            w_sat_pwr = 8'h7F;
        end else if (w_sum < -9'sd128) begin
            w_sat_pwr = 8'h80;
        end else begin
            w_sat_pwr = w_sum[7:0];
        end
        w_uni_pwr = (i_peer_time_remaining == 8'd0) ? r_max_pwr : w_sat_pwr;
    end

    // start-of-event state and failed-attempt charge
    assign w_ls0     = (r_gateway && (r_ls == LS_UNSYNC)) ? LS_IDLE : r_ls;
    assign w_att_inc = r_att + 4'd1;
    assign w_reach   = (w_att_inc >= r_max_att);

    // event decision
    always_comb begin
        t_entry     s_head;
        t_qptr      s_rd;
        t_qcnt      s_cnt;
        logic       s_drop;
        t_out_word  s_send;
        t_out_word  s_dropw;

        n_ls     = r_ls;
        n_att    = r_att;
        n_radio  = r_radio;
        n_rd_ptr = r_rd_ptr;
        n_wr_ptr = r_wr_ptr;
        n_cnt    = r_cnt;
        w_we     = 1'b0;
        w_wdata  = '{hop: i_next_hop, handle: i_packet_handle};
        w_word0  = '0;
        w_word1  = '0;
        w_push_n = 2'd0;
        s_head   = w_head;
        s_rd     = r_rd_ptr;
        s_cnt    = r_cnt;
        s_drop   = 1'b0;
        s_send   = '0;
        s_dropw  = '{action: ACT_DROPPED, power: 8'd0, peer: w_head.hop,
                     handle: w_head.handle, ls: LS_IDLE, last: 1'b0};

        if (w_accept) begin
            case (w_op)
                // slot tick
                OP_TICK: begin
                    n_ls = w_ls0;
                    if (w_ls0 != LS_UNSYNC) begin
                        if (w_ls0 == LS_EXP_CTS || w_ls0 == LS_EXP_ACK) begin
                            n_att = w_reach ? 4'd0 : w_att_inc;
                            s_drop = w_reach && (r_cnt != '0);
                        end
                        if (s_drop) begin
                            s_head = w_next;
                            s_rd   = qptr_inc(r_rd_ptr);
                            s_cnt  = r_cnt - QC_W'(1);
                        end
                        n_ls = LS_EXP_RTS;
                        if ((s_cnt != '0) && i_send_opportunity) begin
                            if (s_head.hop == r_bcast_addr) begin
                                n_radio = r_max_pwr;
                                s_send  = '{action: ACT_BCAST, power: r_max_pwr,
                                            peer: s_head.hop, handle: s_head.handle,
                                            ls: LS_IDLE, last: 1'b0};
                                s_rd    = qptr_inc(s_rd);
                                s_cnt   = s_cnt - QC_W'(1);
                                n_ls    = LS_IDLE;
                            end else begin
                                n_radio = w_uni_pwr;
                                s_send  = '{action: (i_peer_time_remaining < r_rsi_thr) ?
                                                    ACT_RTS_RSI : ACT_RTS,
                                            power: w_uni_pwr, peer: s_head.hop,
                                            handle: s_head.handle, ls: LS_IDLE,
                                            last: 1'b0};
                                n_ls    = LS_EXP_CTS;
                            end
                            if (s_drop) begin
                                w_word0  = s_dropw;
                                w_word1  = s_send;
                                w_push_n = 2'd2;
                            end else begin
                                w_word0  = s_send;
                                w_push_n = 2'd1;
                            end
                        end else if (s_drop) begin
                            w_word0  = s_dropw;
                            w_push_n = 2'd1;
                        end
                        n_rd_ptr = s_rd;
                        n_cnt    = s_cnt;
                    end
                end
                // received rts
                OP_RTS_RX: begin
                    if (w_ls0 != LS_UNSYNC && w_ls0 != LS_EXP_RTS) begin
                        n_ls = LS_IDLE;
                    end else if (i_frame_destination == r_own_addr) begin
                        n_radio  = r_max_pwr;
                        w_word0  = '{action: ACT_CTS, power: r_max_pwr,
                                     peer: i_frame_source, handle: 8'd0,
                                     ls: LS_IDLE, last: 1'b0};
                        w_push_n = 2'd1;
                        n_ls     = LS_EXP_DATA;
                    end else begin
                        n_ls = LS_EXP_RTS;
                    end
                end
                // received cts or ack
                OP_CTS_RX, OP_ACK_RX: begin
                    n_ls = LS_IDLE;
                    if (((w_op == OP_CTS_RX && w_ls0 == LS_EXP_CTS) ||
                         (w_op == OP_ACK_RX && w_ls0 == LS_EXP_ACK)) &&
                        (r_cnt != '0)) begin
                        if (w_head.hop != i_frame_source) begin
                            n_att = w_reach ? 4'd0 : w_att_inc;
                            if (w_reach) begin
                                w_word0  = s_dropw;
                                w_push_n = 2'd1;
                                n_rd_ptr = qptr_inc(r_rd_ptr);
                                n_cnt    = r_cnt - QC_W'(1);
                            end
                        end else if (w_op == OP_CTS_RX) begin
                            w_word0  = '{action: ACT_DATA, power: r_radio,
                                         peer: w_head.hop, handle: w_head.handle,
                                         ls: LS_IDLE, last: 1'b0};
                            w_push_n = 2'd1;
                            n_ls     = LS_EXP_ACK;
                        end else begin
                            w_word0  = '{action: ACT_DELIVERED, power: 8'd0,
                                         peer: w_head.hop, handle: w_head.handle,
                                         ls: LS_IDLE, last: 1'b0};
                            w_push_n = 2'd1;
                            n_rd_ptr = qptr_inc(r_rd_ptr);
                            n_cnt    = r_cnt - QC_W'(1);
                            n_att    = 4'd0;
                        end
                    end
                end
                // enqueue request
                OP_ENQUEUE: begin
                    n_ls     = w_ls0;
                    w_push_n = 2'd1;
                    if (r_cnt >= QC_W'(QUEUE_DEPTH)) begin
                        w_word0 = '{action: ACT_REJECTED, power: 8'd0, peer: i_next_hop,
                                    handle: i_packet_handle, ls: LS_IDLE, last: 1'b0};
                    end else begin
                        w_we     = 1'b1;
                        n_wr_ptr = qptr_inc(r_wr_ptr);
                        n_cnt    = r_cnt + QC_W'(1);
                        w_word0  = '{action: ACT_ACCEPTED, power: 8'd0, peer: i_next_hop,
                                     handle: i_packet_handle, ls: LS_IDLE, last: 1'b0};
                    end
                end
                OP_OTHER: begin
                    n_ls = LS_IDLE;
                end
                default: ;
            endcase
        end

        // final link state and last marker on the emitted words
        w_word0.ls = n_ls;
        w_word1.ls = n_ls;
        w_word0.last = (w_push_n == 2'd1);
        w_word1.last = 1'b1;
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ls     <= LS_UNSYNC;
            r_att    <= 4'd0;
            r_radio  <= 8'd0;
            r_rd_ptr <= '0;
            r_wr_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_ls     <= n_ls;
            r_att    <= n_att;
            r_radio  <= n_radio;
            r_rd_ptr <= n_rd_ptr;
            r_wr_ptr <= n_wr_ptr;
            r_cnt    <= n_cnt;
        end
    end

    // packet queue storage, head and second entry prefetched every cycle
    rclm_queue_ram u_queue_ram (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (r_wr_ptr),
        .i_wdata   (w_wdata),
        .i_raddr_a (n_rd_ptr),
        .i_raddr_b (qptr_inc(n_rd_ptr)),
        .o_rdata_a (w_head),
        .o_rdata_b (w_next)
    );

    // result queue
    rclm_result_queue u_result_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push_n (w_push_n),
        .i_word0  (w_word0),
        .i_word1  (w_word1),
        .o_room2  (w_room2),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready),
        .o_word   (w_oword)
    );

    assign o_action         = w_oword.action;
    assign o_tx_power       = $signed(w_oword.power);
    assign o_peer_address   = w_oword.peer;
    assign o_result_handle  = w_oword.handle;
    assign o_link_state_out = w_oword.ls;
    assign o_last           = w_oword.last;

endmodule

[sv/rclm_queue_ram.sv]
// ----------------------------------------------------------------------------
// rclm_queue_ram
// Packet queue storage: one write port, two registered read ports, with
// same-cycle write data forwarded to a read of the same entry.
// ----------------------------------------------------------------------------
module rclm_queue_ram (
    input  logic            i_clk,
    input  logic            i_we,
    input  rclm_pkg::t_qptr  i_waddr,
    input  rclm_pkg::t_entry i_wdata,
    input  rclm_pkg::t_qptr  i_raddr_a,
    input  rclm_pkg::t_qptr  i_raddr_b,
    output rclm_pkg::t_entry o_rdata_a,
    output rclm_pkg::t_entry o_rdata_b
);
    import rclm_pkg::*;

    t_entry r_mem [QUEUE_DEPTH];
    t_entry r_rd_a;
    t_entry r_rd_b;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read ports with write forwarding
    always_ff @(posedge i_clk) begin
        r_rd_a <= (i_we && (i_waddr == i_raddr_a)) ? i_wdata : r_mem[i_raddr_a];
        r_rd_b <= (i_we && (i_waddr == i_raddr_b)) ? i_wdata : r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rd_a;
    assign o_rdata_b = r_rd_b;

endmodule

[sv/rclm_result_queue.sv]
// ----------------------------------------------------------------------------
// rclm_result_queue
// Small result queue: takes up to two words a cycle, hands out one word a
// cycle on a valid/ready channel.
// ----------------------------------------------------------------------------
module rclm_result_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [1:0]         i_push_n,
    input  rclm_pkg::t_out_word i_word0,
    input  rclm_pkg::t_out_word i_word1,
    output logic               o_room2,
    output logic               o_valid,
    input  logic               i_ready,
    output rclm_pkg::t_out_word o_word
);
    import rclm_pkg::*;

    t_out_word r_q [OQ_DEPTH];
    t_optr     r_wp;
    t_optr     r_rp;
    t_ocnt     r_cnt;
    t_optr     n_wp;
    t_optr     n_rp;
    t_ocnt     n_cnt;
    logic      w_pop;

    assign w_pop   = (r_cnt != '0) && i_ready;
    assign o_valid = (r_cnt != '0);
    assign o_word  = r_q[r_rp];
    assign o_room2 = (r_cnt <= OC_W'(OQ_DEPTH - 2));

    // pointer and count update
    always_comb begin
        n_wp  = r_wp + OA_W'(i_push_n);
        n_rp  = w_pop ? r_rp + OA_W'(1) : r_rp;
        n_cnt = r_cnt + OC_W'(i_push_n) - OC_W'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // word storage
    always_ff @(posedge i_clk) begin
        if (i_push_n != 2'd0) begin
            r_q[r_wp] <= i_word0;
        end
        if (i_push_n == 2'd2) begin
            r_q[r_wp + OA_W'(1)] <= i_word1;
        end
    end

endmodule
